/* src/imf_pkg.sv */
// ----------------------------------------------------------------------------
// Interval merge package
// Widths and item types shared by the interval merger.
// ----------------------------------------------------------------------------
package imf_pkg;

	// Coordinate width of a range start; widths are one bit narrower.
	localparam int POS_BITS = 32;
	localparam int WID_BITS = POS_BITS - 1;
	// Furthest end and frame offset need two bits beyond a coordinate.
	localparam int SUM_BITS = POS_BITS + 2;
	// Differences of a coordinate and a stored sum need one more bit.
	localparam int CALC_BITS = POS_BITS + 3;

	// Result buffer: one item can produce two results.
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_AW = $clog2(OBUF_DEPTH);
	localparam int OBUF_CW = $clog2(OBUF_DEPTH + 1);

	typedef struct packed {
		logic signed [POS_BITS-1:0] range_start;
		logic [WID_BITS-1:0] range_width;
		logic last_item;
	} imf_in_t;

	typedef struct packed {
		logic inframe_valid;
		logic signed [POS_BITS-1:0] inframe_position;
		logic merged_valid;
		logic signed [POS_BITS-1:0] merged_start;
		logic [WID_BITS-1:0] merged_width;
		logic last_result;
	} imf_out_t;

endpackage

/* src/interval_merge_with_frame_offsets.sv */
// ----------------------------------------------------------------------------
// Interval merge with frame offsets
// Merges overlapping or touching ranges and reports in-frame starts.
// ----------------------------------------------------------------------------
// A range item is registered on entry and resolved once the four-entry result
// buffer has room for two more results; while it has, one item is taken per
// clock. An item yields up to two results: the range it closes and/or its
// in-frame start (when emit_inframe is set), then the flush of the open range
// on the item marked last_item. The result port drains one result per clock
// while out_stall is low, so a run of items that give two results fills the
// buffer and stalls the input. Write emit_inframe only while the block is idle.
module interval_merge_with_frame_offsets (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  imf_pkg::imf_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output imf_pkg::imf_out_t out_item,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import imf_pkg::*;

	localparam logic signed [CALC_BITS-1:0] SAT_HI =
		CALC_BITS'((64'(1) << (POS_BITS - 1)) - 64'(1));
	localparam logic signed [CALC_BITS-1:0] ONE = CALC_BITS'(1);

	function automatic logic signed [POS_BITS-1:0] sat_pos(logic signed [CALC_BITS-1:0] v);
		logic signed [CALC_BITS-1:0] c;
		c = v;
		if (c > SAT_HI) begin
			c = SAT_HI;
		end
		if (c < -SAT_HI) begin
			c = -SAT_HI;
		end
		return c[POS_BITS-1:0];
	endfunction

	function automatic logic [WID_BITS-1:0] sat_wid(logic signed [CALC_BITS-1:0] v);
		logic signed [CALC_BITS-1:0] c;
		c = v;
		if (c < 0) begin
			c = '0;
		end
		if (c > SAT_HI) begin
			c = SAT_HI;
		end
		return c[WID_BITS-1:0];
	endfunction

	// Configuration
	logic emit_inframe_q;

	// Input register
	logic    valid_s1;
	imf_in_t item_s1;

	// Merge state
	logic                       open_valid_q;
	logic signed [POS_BITS-1:0] open_start_q;
	logic signed [SUM_BITS-1:0] furthest_end_q;
	logic signed [SUM_BITS-1:0] frame_offset_q;

	// Result buffer
	imf_out_t           obuf_q [OBUF_DEPTH];
	logic [OBUF_AW-1:0] obuf_wp_q;
	logic [OBUF_AW-1:0] obuf_rp_q;
	logic [OBUF_CW-1:0] obuf_cnt_q;

	logic proc;
	logic pop;
	logic load;

	logic signed [CALC_BITS-1:0] start_c;
	logic signed [CALC_BITS-1:0] width_c;
	logic signed [CALC_BITS-1:0] end_c;
	logic signed [CALC_BITS-1:0] fe_c;
	logic signed [CALC_BITS-1:0] ofs_c;
	logic signed [CALC_BITS-1:0] os_c;
	logic signed [CALC_BITS-1:0] fe_next;
	logic signed [CALC_BITS-1:0] ofs_next;
	logic signed [CALC_BITS-1:0] os_next;
	logic                        closed;

	imf_out_t           res0;
	imf_out_t           res1;
	logic               push0;
	logic               push1;
	logic [OBUF_AW-1:0] wp1;
	logic [OBUF_AW-1:0] wp_adv;
	logic [OBUF_CW-1:0] push_n;

	assign pop = out_valid && !out_stall;
	assign proc = valid_s1 && (obuf_cnt_q <= OBUF_CW'(OBUF_DEPTH - 2));
	assign in_stall = valid_s1 && !proc;
	assign load = in_valid && !in_stall;

	assign out_valid = (obuf_cnt_q != '0);
	assign out_item = obuf_q[obuf_rp_q];

	// Merge decision for the registered item.
	always_comb begin
		start_c = {{(CALC_BITS-POS_BITS){item_s1.range_start[POS_BITS-1]}},
			item_s1.range_start};
		width_c = {{(CALC_BITS-WID_BITS){1'b0}}, item_s1.range_width};
		end_c = start_c + width_c - ONE;
		fe_c = {{(CALC_BITS-SUM_BITS){furthest_end_q[SUM_BITS-1]}}, furthest_end_q};
		ofs_c = {{(CALC_BITS-SUM_BITS){frame_offset_q[SUM_BITS-1]}}, frame_offset_q};
		os_c = {{(CALC_BITS-POS_BITS){open_start_q[POS_BITS-1]}}, open_start_q};
		closed = 1'b0;
		fe_next = fe_c;
		ofs_next = ofs_c;
		os_next = os_c;
		if (!open_valid_q) begin
			fe_next = end_c;
			ofs_next = start_c - ONE;
			os_next = start_c;
		end else if (start_c > fe_c + ONE) begin
			// A positive gap closes the open range and shifts the frame.
			closed = 1'b1;
			fe_next = end_c;
			ofs_next = ofs_c + (start_c - fe_c - ONE);
			os_next = start_c;
		end else if (end_c > fe_c) begin
			fe_next = end_c;
		end
	end

	// Results; the open range width is furthest end minus start plus one, saturated.
	always_comb begin
		res0 = '0;
		res1 = '0;
		if (emit_inframe_q) begin
			res0.inframe_valid = 1'b1;
			res0.inframe_position = sat_pos(start_c - ofs_next);
		end
		if (closed) begin
			res0.merged_valid = 1'b1;
			res0.merged_start = open_start_q;
			res0.merged_width = sat_wid(fe_c - os_c + ONE);
		end
		res0.last_result = !item_s1.last_item;
		res1.merged_valid = 1'b1;
		res1.merged_start = os_next[POS_BITS-1:0];
		res1.merged_width = sat_wid(fe_next - os_next + ONE);
		res1.last_result = 1'b1;

		push0 = proc && (closed || emit_inframe_q);
		push1 = proc && item_s1.last_item;
		wp1 = push0 ? obuf_wp_q + OBUF_AW'(1) : obuf_wp_q;
		push_n = OBUF_CW'(push0) + OBUF_CW'(push1);
		wp_adv = obuf_wp_q + push_n[OBUF_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_inframe_q <= 1'b1;
		end else if (cfg_we) begin
			emit_inframe_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_valid_q <= 1'b0;
			open_start_q <= '0;
			furthest_end_q <= '0;
			frame_offset_q <= '0;
		end else if (proc) begin
			if (item_s1.last_item) begin
				// End of set: the next item opens a fresh set.
				open_valid_q <= 1'b0;
				open_start_q <= '0;
				furthest_end_q <= '0;
				frame_offset_q <= '0;
			end else begin
				open_valid_q <= 1'b1;
				open_start_q <= os_next[POS_BITS-1:0];
				furthest_end_q <= fe_next[SUM_BITS-1:0];
				frame_offset_q <= ofs_next[SUM_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_wp_q <= '0;
			obuf_rp_q <= '0;
			obuf_cnt_q <= '0;
		end else begin
			obuf_wp_q <= wp_adv;
			if (pop) begin
				obuf_rp_q <= obuf_rp_q + OBUF_AW'(1);
			end
			obuf_cnt_q <= obuf_cnt_q + push_n - OBUF_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < OBUF_DEPTH; i++) begin
			if (push0 && (obuf_wp_q == OBUF_AW'(i))) begin
				obuf_q[i] <= res0;
			end else if (push1 && (wp1 == OBUF_AW'(i))) begin
				obuf_q[i] <= res1;
			end
		end
	end

	// The buffer never holds more results than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		obuf_cnt_q <= OBUF_CW'(OBUF_DEPTH))
		else $error("result buffer overflow");

	// A last item, or any item while in-frame starts are on, leaves the output side non-empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && (item_s1.last_item || emit_inframe_q)) |=> out_valid)
		else $error("result missing after item");

	// The last item of a set closes the merge state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(proc && item_s1.last_item) |=> !open_valid_q)
		else $error("set not closed after last item");

	// The frame offset never passes the furthest end of an open set.
	assert property (@(posedge clk) disable iff (!arst_n)
		open_valid_q |-> (frame_offset_q <= furthest_end_q))
		else $error("frame offset beyond furthest end");

endmodule

/* tb/tb_interval_merge_with_frame_offsets.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval merge with frame offsets testbench
// Feeds sets of ranges, mostly ascending with overlaps, touches and gaps, plus
// out-of-order and raw random items, under random idling on both ports. A
// model of the merge state predicts each item's results, and the results are
// checked field by field. The emit_inframe register is toggled between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_interval_merge_with_frame_offsets;
	import imf_pkg::*;

	localparam longint POS_MAX = (longint'(1) << (POS_BITS - 1)) - 1;
	localparam longint POS_MIN = -(longint'(1) << (POS_BITS - 1));
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASE_ITEMS = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	imf_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	imf_out_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	imf_in_t range_pending_q[$];
	imf_out_t merge_expect_q[$];
	bit in_taken = 1'b0;
	int unsigned in_gap = 0;
	int unsigned stall_left = 0;
	int unsigned cyc_cnt = 0;
	bit mismatch_seen = 1'b0;

	// Model copy of the register and of the merge state.
	bit inframe_en = 1'b1;
	bit run_open = 1'b0;
	longint run_start = 0;
	longint run_width = 0;
	longint run_end = 0;
	longint frame_ofs = 0;

	interval_merge_with_frame_offsets u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic signed [POS_BITS-1:0] sat_pos(longint v);
		if (v > POS_MAX) v = POS_MAX;
		if (v < -POS_MAX) v = -POS_MAX;
		return v[POS_BITS-1:0];
	endfunction

	function automatic logic [WID_BITS-1:0] sat_wid(longint v);
		if (v < 0) v = 0;
		if (v > POS_MAX) v = POS_MAX;
		return v[WID_BITS-1:0];
	endfunction

	task automatic merge_predict(input imf_in_t it);
		longint s;
		longint w;
		longint e;
		longint gap;
		bit closed;
		imf_out_t r;
		imf_out_t f;
		s = $signed(it.range_start);
		w = it.range_width;
		e = s + w - 1;
		closed = 1'b0;
		r = '0;
		if (!run_open) begin
			run_open = 1'b1;
			run_start = s;
			run_width = w;
			frame_ofs = s - 1;
			run_end = e;
		end else begin
			gap = s - run_end - 1;
			if (gap > 0) begin
				r.merged_valid = 1'b1;
				r.merged_start = run_start[POS_BITS-1:0];
				r.merged_width = sat_wid(run_width);
				closed = 1'b1;
				run_start = s;
				run_width = w;
				frame_ofs += gap;
				run_end = e;
			end else if (e > run_end) begin
				run_width += e - run_end;
				run_end = e;
			end
		end
		if (inframe_en) begin
			r.inframe_valid = 1'b1;
			r.inframe_position = sat_pos(s - frame_ofs);
		end
		if (closed || inframe_en) begin
			r.last_result = !it.last_item;
			merge_expect_q.push_back(r);
		end
		if (it.last_item) begin
			// The flush carries the open range and ends the set.
			f = '0;
			f.merged_valid = 1'b1;
			f.merged_start = run_start[POS_BITS-1:0];
			f.merged_width = sat_wid(run_width);
			f.last_result = 1'b1;
			merge_expect_q.push_back(f);
			run_open = 1'b0;
			run_start = 0;
			run_width = 0;
			run_end = 0;
			frame_ofs = 0;
		end
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_seen = 1'b1;
		end
	endtask

	function automatic int unsigned idle_len(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: inputs change on the falling edge only.
	always @(negedge clk) begin
		if (arst_n) begin
			cyc_cnt <= cyc_cnt + 1;
			if (!in_valid || in_taken) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (range_pending_q.size() > 0) begin
					in_item <= range_pending_q.pop_front();
					in_valid <= 1'b1;
					in_gap <= idle_len(cyc_cnt[9:7] == 3'd0);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= idle_len(cyc_cnt[9:7] == 3'd4);
			end
		end
	end

	// Monitor: both handshakes are sampled on the rising edge.
	always @(posedge clk) begin : monitor
		imf_out_t want;
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall)
				merge_predict(in_item);
			if (out_valid && !out_stall) begin
				if (merge_expect_q.size() == 0) begin
					$error("result item with no expectation waiting");
					mismatch_seen = 1'b1;
				end else begin
					want = merge_expect_q.pop_front();
					check_field("inframe_valid", want.inframe_valid, out_item.inframe_valid);
					check_field("inframe_position", $signed(want.inframe_position),
						$signed(out_item.inframe_position));
					check_field("merged_valid", want.merged_valid, out_item.merged_valid);
					check_field("merged_start", $signed(want.merged_start),
						$signed(out_item.merged_start));
					check_field("merged_width", want.merged_width, out_item.merged_width);
					check_field("last_result", want.last_result, out_item.last_result);
				end
			end
		end
	end

	task automatic add_range(longint s, longint w, bit last);
		imf_in_t it;
		it.range_start = s[POS_BITS-1:0];
		it.range_width = w[WID_BITS-1:0];
		it.last_item = last;
		range_pending_q.push_back(it);
	endtask

	function automatic longint pick_width();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r <= 6) return $urandom_range(1, 20);
		if (r <= 8) return $urandom_range(0, 5000);
		return $urandom_range(0, 32'h7fff_ffff);
	endfunction

	task automatic add_random_sets(int unsigned n_items);
		int unsigned done;
		int unsigned len;
		int unsigned r;
		longint pos;
		longint w;
		longint far_end;
		imf_in_t it;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// Raw noise: any bit pattern, set ends at random.
				it.range_start = $urandom;
				it.range_width = WID_BITS'($urandom);
				it.last_item = ($urandom_range(0, 3) == 0);
				range_pending_q.push_back(it);
				done++;
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
					: $urandom_range(1, 8);
				r = $urandom_range(0, 9);
				if (r < 6) pos = longint'($urandom_range(0, 2000)) - 1000;
				else if (r == 6) pos = POS_MAX - $urandom_range(0, 3000);
				else if (r == 7) pos = POS_MIN + $urandom_range(0, 3000);
				else pos = longint'($signed($urandom));
				far_end = pos - 1;
				for (int unsigned k = 0; k < len; k++) begin
					w = pick_width();
					add_range(pos, w, k == len - 1);
					if (pos + w - 1 > far_end) far_end = pos + w - 1;
					r = $urandom_range(0, 99);
					if (r < 35) pos = pos + $urandom_range(0, 32'(w));
					else if (r < 55) pos = far_end + 1;
					else if (r < 85) pos = far_end + 2 + $urandom_range(0, 20);
					else if (r < 92) pos = far_end + 2 + $urandom;
					else pos = pos - $urandom_range(0, 50);
					done++;
				end
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (range_pending_q.size() != 0 || in_valid || merge_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_inframe_en(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		inframe_en = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ranges with in-frame starts on (reset value).
		add_range(10, 5, 1'b0);
		add_range(15, 0, 1'b0);                 // touching, zero width
		add_range(12, 10, 1'b0);                // overlap that extends the end
		add_range(30, 3, 1'b0);                 // gap closes the open range
		add_range(20, 2, 1'b0);                 // out of order, merges
		add_range(40, 1, 1'b1);                 // close and flush together
		add_range(POS_MIN, 0, 1'b1);            // most negative start, one-item set
		add_range(POS_MIN, POS_MAX, 1'b0);
		add_range(-2, POS_MAX, 1'b0);           // merged width goes past the limit
		add_range(POS_MAX, POS_MAX, 1'b1);
		add_range(-POS_MAX, POS_MAX, 1'b0);
		add_range(POS_MAX, 0, 1'b1);            // in-frame start saturates high
		add_range(POS_MAX, 0, 1'b0);
		add_range(POS_MIN, 0, 1'b1);            // in-frame start saturates low
		wait_drained();

		write_inframe_en(1'b0);
		add_range(5, 3, 1'b0);
		add_range(6, 1, 1'b0);                  // no result for these two
		add_range(100, 2, 1'b0);
		add_range(101, 0, 1'b1);                // flush alone
		add_range(-7, 0, 1'b0);
		add_range(-6, POS_MAX, 1'b1);
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			write_inframe_en(p % 2 == 0);
			add_random_sets(RANDOM_PHASE_ITEMS);
			wait_drained();
		end

		if (!mismatch_seen && merge_expect_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#25_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
